[src/radix2_complex_fft_top_assert.svh]
// Assertion macros used by the FFT top module.
`ifndef RADIX2_COMPLEX_FFT_TOP_ASSERT_SVH
`define RADIX2_COMPLEX_FFT_TOP_ASSERT_SVH
// Same-cycle implication, sampled on clk and switched off during reset.
`define RFFT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk and switched off during reset.
`define RFFT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

[src/rfft_pkg.sv]
package rfft_pkg;
	localparam int MAX_LOG2_POINTS = 10;
	localparam int TWIDDLE_BITS = 18;
	localparam int TW_FRAC = TWIDDLE_BITS - 2;
	localparam int DATA_W = 32;
	localparam int AW = MAX_LOG2_POINTS;
	localparam int ROM_AW = MAX_LOG2_POINTS - 1;
	localparam int FRAME_DEPTH = 1 << MAX_LOG2_POINTS;
	localparam int ROM_SIZE = 1 << ROM_AW;
	localparam int PROD_W = TWIDDLE_BITS + DATA_W;
	localparam int ACC_W = PROD_W + 2;
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	typedef enum logic [2:0] {
		STEP_IDLE,
		STEP_CXR,
		STEP_SXI,
		STEP_CXI,
		STEP_SXR,
		STEP_FIN
	} bf_step_t;

	typedef logic signed [TWIDDLE_BITS-1:0] tw_rom_t [ROM_SIZE];

	function automatic longint round_q30(input longint v);
		longint r;
		r = (v + (64'sd1 <<< (29 - TW_FRAC))) >>> (30 - TW_FRAC);
		return r;
	endfunction

	// Restoring shift-and-subtract quotient, used only while building the tables.
	function automatic longint unsigned div_u64(input longint unsigned num,
		input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic tw_rom_t build_rom(input bit want_sin);
		tw_rom_t rom;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint c;
		longint s;
		longint unsigned mm;
		bit flip;
		for (int m = 0; m < ROM_SIZE; m++) begin
			mm = longint'(m);
			flip = 1'b0;
			if (2 * m > ROM_SIZE) begin
				mm = longint'(ROM_SIZE - m);
				flip = 1'b1;
			end
			x = ((PI_Q60 >> 20) * mm) >> (ROM_AW + 10);
			x2 = (x * x) >> 30;
			t = 64'd1 << 30;
			c = longint'(t);
			for (int n = 1; n <= 14; n++) begin
				t = div_u64((t * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
				c = n[0] ? c - longint'(t) : c + longint'(t);
			end
			t = x;
			s = longint'(t);
			for (int n = 1; n <= 14; n++) begin
				t = div_u64((t * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
				s = n[0] ? s - longint'(t) : s + longint'(t);
			end
			c = round_q30(c);
			s = round_q30(s);
			if (want_sin)
				rom[m] = TWIDDLE_BITS'(s);
			else
				rom[m] = TWIDDLE_BITS'(flip ? -c : c);
		end
		return rom;
	endfunction

	localparam tw_rom_t COS_ROM = build_rom(1'b0);
	localparam tw_rom_t SIN_ROM = build_rom(1'b1);
endpackage

[src/rfft_bfly.sv]
module rfft_bfly (
	input  logic                                      clk,
	input  rfft_pkg::bf_step_t                        step,
	input  logic signed [rfft_pkg::TWIDDLE_BITS-1:0] c,
	input  logic signed [rfft_pkg::TWIDDLE_BITS-1:0] s,
	input  logic signed [rfft_pkg::DATA_W-1:0]       xr,
	input  logic signed [rfft_pkg::DATA_W-1:0]       xi,
	output logic signed [rfft_pkg::DATA_W-1:0]       tr,
	output logic signed [rfft_pkg::DATA_W-1:0]       ti
);
	import rfft_pkg::*;

	logic signed [TWIDDLE_BITS-1:0] mul_a;
	logic signed [DATA_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] sum_fin;
	logic signed [DATA_W-1:0] tr_q;
	logic signed [DATA_W-1:0] ti_q;

	function automatic logic signed [DATA_W-1:0] rnd(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = (v + (ACC_W'(1) <<< (TW_FRAC - 1))) >>> TW_FRAC;
		return r[DATA_W-1:0];
	endfunction

	always_comb begin
		unique case (step)
			STEP_CXR: begin
				mul_a = c;
				mul_b = xr;
			end
			STEP_SXI: begin
				mul_a = s;
				mul_b = xi;
			end
			STEP_CXI: begin
				mul_a = c;
				mul_b = xi;
			end
			default: begin
				mul_a = s;
				mul_b = xr;
			end
		endcase
	end

	assign prod_ext = ACC_W'(prod_q);
	assign sum_fin = acc_q + prod_ext;

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (step)
			STEP_SXI: acc_q <= prod_ext;
			STEP_CXI: acc_q <= acc_q - prod_ext;
			STEP_SXR: begin
				tr_q <= rnd(acc_q);
				acc_q <= prod_ext;
			end
			STEP_FIN: ti_q <= rnd(sum_fin);
			default: acc_q <= acc_q;
		endcase
	end

	assign tr = tr_q;
	assign ti = ti_q;
endmodule

[src/radix2_complex_fft_top.sv]
// The load that completes a frame of N = 2^L points starts the transform: bit reversal over N
// indices with each swapped pair rewritten, then (N/2)*L butterflies through read, multiply and
// write states on the single shared multiplier and the frame memory, plus inverse scaling.
// Fetch transaction: the bin is read in a wait state, then shown from the output registers; the
// input frees in idle unless the bin stalls. No transaction is taken during the transform.
// Reset is asynchronous and clears control state; the frame memory is not cleared.
`include "radix2_complex_fft_top_assert.svh"
module radix2_complex_fft_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [0:0]                         cfg_index,
	input  logic [3:0]                         cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               kind,
	input  logic signed [15:0]                 sample_re,
	input  logic signed [15:0]                 sample_im,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [rfft_pkg::DATA_W-1:0] out_re,
	output logic signed [rfft_pkg::DATA_W-1:0] out_im,
	output logic [9:0]                         bin_index,
	output logic                               last_out
);
	import rfft_pkg::*;

	localparam logic [0:0] REG_INVERSE = 1'b0;
	localparam logic [0:0] REG_LOG2 = 1'b1;
	localparam logic KIND_LOAD = 1'b0;

	typedef enum logic [4:0] {
		ST_IDLE, ST_BR_RA, ST_BR_RB, ST_BR_W0, ST_BR_W1,
		ST_BF_RK, ST_BF_RI, ST_BF_M0, ST_BF_M1, ST_BF_M2, ST_BF_M3, ST_BF_M4,
		ST_BF_WK, ST_BF_WI, ST_SC_RD, ST_SC_WR, ST_F_WAIT
	} state_t;

	state_t state_q;
	logic inverse_q;
	logic [3:0] log2_q;
	logic [3:0] l_q;
	logic inv_run_q;
	logic [3:0] stage_q;
	logic [AW-1:0] cnt_q;
	logic [AW:0] load_count_q;
	logic [AW:0] fetch_count_q;
	logic frame_done_q;
	logic signed [TWIDDLE_BITS-1:0] c_q;
	logic signed [TWIDDLE_BITS-1:0] s_q;
	logic signed [DATA_W-1:0] xr_q, xi_q, ar_q, ai_q;
	logic signed [DATA_W-1:0] out_re_q, out_im_q;
	logic [9:0] bin_q;
	logic last_q;
	logic out_valid_q;

	logic [2*DATA_W-1:0] mem [FRAME_DEPTH];
	logic [2*DATA_W-1:0] rd_data_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [2*DATA_W-1:0] wr_data;
	logic wr_en;

	logic [3:0] l_cfg;
	logic [AW:0] n_cfg;
	logic [AW-1:0] n_m1, half_n_m1;
	logic in_acc;
	logic [AW:0] load_pos, load_next;
	logic [AW-1:0] half, j_idx, bf_i, bf_k, rev_full, rev;
	logic [AW-1:0] tw_full;
	logic [ROM_AW-1:0] tw_idx;
	bf_step_t step;
	logic signed [DATA_W-1:0] tr, ti;
	logic signed [DATA_W:0] sc_re, sc_im;

	always_comb begin
		l_cfg = log2_q;
		if (log2_q < 4'd1)
			l_cfg = 4'd1;
		else if (log2_q > 4'(MAX_LOG2_POINTS))
			l_cfg = 4'(MAX_LOG2_POINTS);
	end

	assign n_cfg = (AW+1)'(1) << l_cfg;
	assign n_m1 = AW'(((AW+1)'(1) << l_q) - (AW+1)'(1));
	assign half_n_m1 = n_m1 >> 1;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc = in_valid && !in_stall;
	assign load_pos = frame_done_q ? '0 : load_count_q;
	assign load_next = load_pos + (AW+1)'(1);

	assign half = AW'(1) << (stage_q - 4'd1);
	assign j_idx = cnt_q & (half - AW'(1));
	assign bf_i = ((cnt_q >> (stage_q - 4'd1)) << stage_q) | j_idx;
	assign bf_k = bf_i | half;
	assign tw_full = j_idx << (4'(MAX_LOG2_POINTS) - stage_q);
	assign tw_idx = tw_full[ROM_AW-1:0];

	always_comb begin
		for (int b = 0; b < AW; b++)
			rev_full[b] = cnt_q[AW-1-b];
	end
	assign rev = rev_full >> (4'(MAX_LOG2_POINTS) - l_q);

	assign sc_re = ((DATA_W+1)'(signed'(rd_data_q[2*DATA_W-1:DATA_W]))
		+ ((DATA_W+1)'(1) << (l_q - 4'd1))) >>> l_q;
	assign sc_im = ((DATA_W+1)'(signed'(rd_data_q[DATA_W-1:0]))
		+ ((DATA_W+1)'(1) << (l_q - 4'd1))) >>> l_q;

	always_comb begin
		unique case (state_q)
			ST_BF_M0: step = STEP_CXR;
			ST_BF_M1: step = STEP_SXI;
			ST_BF_M2: step = STEP_CXI;
			ST_BF_M3: step = STEP_SXR;
			ST_BF_M4: step = STEP_FIN;
			default: step = STEP_IDLE;
		endcase
	end

	rfft_bfly u_bfly (
		.clk  (clk),
		.step (step),
		.c    (c_q),
		.s    (s_q),
		.xr   (xr_q),
		.xi   (xi_q),
		.tr   (tr),
		.ti   (ti)
	);

	always_comb begin
		wr_en = 1'b0;
		wr_addr = cnt_q;
		wr_data = rd_data_q;
		unique case (state_q)
			ST_IDLE: begin
				wr_en = in_acc && (kind == KIND_LOAD);
				wr_addr = load_pos[AW-1:0];
				wr_data = {DATA_W'(sample_re), DATA_W'(sample_im)};
			end
			ST_BR_W0: wr_en = 1'b1;
			ST_BR_W1: begin
				wr_en = 1'b1;
				wr_addr = rev;
				wr_data = {ar_q, xr_q};
			end
			ST_BF_WK: begin
				wr_en = 1'b1;
				wr_addr = bf_k;
				wr_data = {ar_q - tr, ai_q - ti};
			end
			ST_BF_WI: begin
				wr_en = 1'b1;
				wr_addr = bf_i;
				wr_data = {ar_q + tr, ai_q + ti};
			end
			ST_SC_WR: begin
				wr_en = 1'b1;
				wr_data = {sc_re[DATA_W-1:0], sc_im[DATA_W-1:0]};
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE: rd_addr = fetch_count_q[AW-1:0];
			ST_BR_RB: rd_addr = rev;
			ST_BF_RK: rd_addr = bf_k;
			ST_BF_RI: rd_addr = bf_i;
			default: rd_addr = cnt_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			inverse_q <= 1'b0;
			log2_q <= 4'(MAX_LOG2_POINTS);
			l_q <= 4'(MAX_LOG2_POINTS);
			inv_run_q <= 1'b0;
			stage_q <= 4'd1;
			cnt_q <= '0;
			load_count_q <= '0;
			fetch_count_q <= '0;
			frame_done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_INVERSE: inverse_q <= cfg_data[0];
					REG_LOG2: log2_q <= cfg_data;
					default: log2_q <= log2_q;
				endcase
			end
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && kind == KIND_LOAD) begin
						frame_done_q <= 1'b0;
						if (frame_done_q)
							fetch_count_q <= '0;
						if (load_next >= n_cfg) begin
							load_count_q <= '0;
							l_q <= l_cfg;
							inv_run_q <= inverse_q;
							cnt_q <= '0;
							state_q <= ST_BR_RA;
						end else begin
							load_count_q <= load_next;
						end
					end else if (in_acc && frame_done_q) begin
						bin_q <= fetch_count_q[9:0];
						last_q <= fetch_count_q >= n_cfg - (AW+1)'(1);
						if (fetch_count_q >= n_cfg - (AW+1)'(1)) begin
							frame_done_q <= 1'b0;
							fetch_count_q <= '0;
						end else begin
							fetch_count_q <= fetch_count_q + (AW+1)'(1);
						end
						state_q <= ST_F_WAIT;
					end
				end
				ST_F_WAIT: begin
					out_re_q <= rd_data_q[2*DATA_W-1:DATA_W];
					out_im_q <= rd_data_q[DATA_W-1:0];
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_BR_RA: begin
					if (cnt_q < rev) begin
						state_q <= ST_BR_RB;
					end else if (cnt_q == n_m1) begin
						cnt_q <= '0;
						stage_q <= 4'd1;
						state_q <= ST_BF_RK;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_BR_RB: begin
					ar_q <= rd_data_q[2*DATA_W-1:DATA_W];
					xr_q <= rd_data_q[DATA_W-1:0];
					state_q <= ST_BR_W0;
				end
				ST_BR_W0: state_q <= ST_BR_W1;
				ST_BR_W1: begin
					if (cnt_q == n_m1) begin
						cnt_q <= '0;
						stage_q <= 4'd1;
						state_q <= ST_BF_RK;
					end else begin
						cnt_q <= cnt_q + AW'(1);
						state_q <= ST_BR_RA;
					end
				end
				ST_BF_RK: begin
					c_q <= COS_ROM[tw_idx];
					s_q <= inv_run_q ? SIN_ROM[tw_idx] : -SIN_ROM[tw_idx];
					state_q <= ST_BF_RI;
				end
				ST_BF_RI: begin
					xr_q <= rd_data_q[2*DATA_W-1:DATA_W];
					xi_q <= rd_data_q[DATA_W-1:0];
					state_q <= ST_BF_M0;
				end
				ST_BF_M0: begin
					ar_q <= rd_data_q[2*DATA_W-1:DATA_W];
					ai_q <= rd_data_q[DATA_W-1:0];
					state_q <= ST_BF_M1;
				end
				ST_BF_M1: state_q <= ST_BF_M2;
				ST_BF_M2: state_q <= ST_BF_M3;
				ST_BF_M3: state_q <= ST_BF_M4;
				ST_BF_M4: state_q <= ST_BF_WK;
				ST_BF_WK: state_q <= ST_BF_WI;
				ST_BF_WI: begin
					if (cnt_q == half_n_m1) begin
						cnt_q <= '0;
						if (stage_q == l_q) begin
							if (inv_run_q) begin
								state_q <= ST_SC_RD;
							end else begin
								frame_done_q <= 1'b1;
								fetch_count_q <= '0;
								state_q <= ST_IDLE;
							end
						end else begin
							stage_q <= stage_q + 4'd1;
							state_q <= ST_BF_RK;
						end
					end else begin
						cnt_q <= cnt_q + AW'(1);
						state_q <= ST_BF_RK;
					end
				end
				ST_SC_RD: state_q <= ST_SC_WR;
				ST_SC_WR: begin
					if (cnt_q == n_m1) begin
						frame_done_q <= 1'b1;
						fetch_count_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
						state_q <= ST_SC_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_re = out_re_q;
	assign out_im = out_im_q;
	assign bin_index = bin_q;
	assign last_out = last_q;

	`RFFT_ASSERT_NOW(a_busy_stalls, state_q != ST_IDLE, in_stall, "input taken while busy")
	`RFFT_ASSERT_NEXT(a_fetch_shows, state_q == ST_F_WAIT, out_valid_q, "fetched bin not shown")
	`RFFT_ASSERT_NOW(a_done_empty, frame_done_q, load_count_q == '0, "load count set on done frame")
endmodule
